// ===== rtl/core/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

    // default sizes of the store
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // fixed port widths
    localparam int FIELD_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // request codes
    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_SET = 1'b1
    } t_req_type;

    // command from the handshake stage to the store
    typedef struct packed {
        logic      fire;
        t_req_type op;
    } t_store_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/lru_key_value_cache_unit.sv =====
`default_nettype none

// channel | direction | handshake             | payload
// --------+-----------+-----------------------+----------------------------------------
// request | in        | i_in_valid/o_in_stall | i_req_type, i_lookup_key, i_write_value
// result  | out       | o_out_valid/i_out_stall | o_hit, o_read_value
// config  | in        | i_cfg_we              | i_cfg_wdata (capacity)
//
// one request word per cycle while o_in_stall is low; a get result passes the request and result registers
// lookup, rank update and insert all run combinationally between the request
// register and the result register; a set gives no result word
// reset clears valid marks, ranks, occupancy and capacity returns to 16
// a get waits in the request register while the result word is stalled;
// sets keep flowing under a stalled result

module lru_key_value_cache_unit #(
    parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire                                  i_req_type,
    input  wire signed [lkvc_pkg::FIELD_BITS-1:0] i_lookup_key,
    input  wire signed [lkvc_pkg::FIELD_BITS-1:0] i_write_value,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic                                 o_hit,
    output logic signed [lkvc_pkg::FIELD_BITS-1:0] o_read_value,
    input  wire                                  i_cfg_we,
    input  wire [lkvc_pkg::CAP_BITS-1:0]         i_cfg_wdata
);
    import lkvc_pkg::*;

    localparam int MISS_ONES = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam logic [FIELD_BITS-1:0] MISS_VALUE =
        FIELD_BITS'((65'd1 << MISS_ONES) - 65'd1);

    logic [CAP_BITS-1:0]   r_capacity;
    logic                  r_in_valid;
    t_req_type             r_in_type;
    logic [KEY_BITS-1:0]   r_in_key;
    logic [VALUE_BITS-1:0] r_in_value;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [FIELD_BITS-1:0] r_out_value;

    logic [FIELD_BITS+KEY_BITS-1:0]   key_ext;
    logic [FIELD_BITS+VALUE_BITS-1:0] val_ext;
    logic [FIELD_BITS+VALUE_BITS-1:0] rd_ext;
    logic                             out_free;
    logic                             fire;
    logic                             in_accept;
    t_store_cmd                       cmd;
    logic                             st_hit;
    logic [VALUE_BITS-1:0]            st_value;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // sign-extend fields, then keep the stored widths
    assign key_ext = {{KEY_BITS{i_lookup_key[FIELD_BITS-1]}}, i_lookup_key};
    assign val_ext = {{VALUE_BITS{i_write_value[FIELD_BITS-1]}}, i_write_value};

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && ((r_in_type == REQ_SET) || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_type  <= t_req_type'(i_req_type);
            r_in_key   <= key_ext[KEY_BITS-1:0];
            r_in_value <= val_ext[VALUE_BITS-1:0];
        end
    end

    assign cmd.fire = fire;
    assign cmd.op   = r_in_type;

    lkvc_store #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_key     (r_in_key),
        .i_value   (r_in_value),
        .i_capacity(r_capacity),
        .o_hit     (st_hit),
        .o_value   (st_value)
    );

    // stored value zero-extended or cut to the field width
    assign rd_ext = {{FIELD_BITS{1'b0}}, st_value};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && (r_in_type == REQ_GET)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (r_in_type == REQ_GET)) begin
            r_out_hit   <= st_hit;
            r_out_value <= st_hit ? rd_ext[FIELD_BITS-1:0] : MISS_VALUE;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

    // a miss always carries the miss pattern
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_value == MISS_VALUE))
        else $error("miss result without miss pattern");

    // a processed get always yields a result word
    a_get_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in_type == REQ_GET)) |=> r_out_valid)
        else $error("get processed without result");

    // a set never creates a result word
    a_set_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in_type == REQ_SET) && !(r_out_valid && i_out_stall))
        |=> !r_out_valid)
        else $error("set produced a result");

    // the request side stalls only on a waiting get
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && (r_in_type == REQ_GET) && r_out_valid && i_out_stall))
        else $error("request stall without cause");

endmodule

`default_nettype wire

// ===== rtl/core/lkvc_store.sv =====
`default_nettype none

module lkvc_store #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  lkvc_pkg::t_store_cmd         i_cmd,
    input  wire [KEY_BITS-1:0]           i_key,
    input  wire [VALUE_BITS-1:0]         i_value,
    input  wire [lkvc_pkg::CAP_BITS-1:0] i_capacity,
    output logic                         o_hit,
    output logic [VALUE_BITS-1:0]        o_value
);
    import lkvc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [RANK_W-1:0]     r_rank [ENTRIES];
    logic [RANK_W-1:0]     n_rank [ENTRIES];
    logic [CNT_W-1:0]      r_used, n_used;
    logic [KEY_BITS-1:0]   r_key  [ENTRIES];
    logic [VALUE_BITS-1:0] r_val  [ENTRIES];

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] valid_ae;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   slot_idx;
    logic [RANK_W-1:0]  hit_rank;
    logic [CNT_W-1:0]   eff_cap;
    logic [CNT_W-1:0]   used_m1;
    logic               evict;
    logic               do_touch;
    logic               do_insert;
    logic               do_write;

    // capacity clamped to one .. ENTRIES
    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(i_capacity) > ENTRIES) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(i_capacity);
        end
    end

    // parallel key compare, lowest matching entry wins
    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            hit_vec[i] = r_valid[i] && (r_key[i] == i_key);
            if (hit_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign o_hit    = |hit_vec;
    assign o_value  = r_val[hit_idx];
    assign hit_rank = r_rank[hit_idx];

    // the oldest valid entry holds rank used_count - 1
    assign used_m1 = r_used - CNT_W'(1);
    assign evict   = !o_hit && (r_used >= eff_cap);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            victim_vec[i] = evict && r_valid[i] && (r_rank[i] == used_m1[RANK_W-1:0]);
        end
    end

    assign valid_ae = r_valid & ~victim_vec;

    // first free entry after eviction
    always_comb begin
        slot_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_ae[i]) begin
                slot_idx = IDX_W'(i);
            end
        end
    end

    assign do_touch  = i_cmd.fire && o_hit;
    assign do_insert = i_cmd.fire && !o_hit && (i_cmd.op == REQ_SET);
    assign do_write  = do_touch && (i_cmd.op == REQ_SET);

    // rank, valid and occupancy update
    always_comb begin
        n_valid = r_valid;
        n_used  = r_used;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (do_touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                    n_rank[i] = RANK_W'(r_rank[i] + 1'b1);
                end
            end
            n_rank[hit_idx] = '0;
        end else if (do_insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_ae[i]) begin
                    n_rank[i] = RANK_W'(r_rank[i] + 1'b1);
                end else if (victim_vec[i]) begin
                    n_rank[i] = '0;
                end
            end
            n_rank[slot_idx]  = '0;
            n_valid           = valid_ae;
            n_valid[slot_idx] = 1'b1;
            if (!evict) begin
                n_used = CNT_W'(r_used + 1'b1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_used  <= n_used;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // key and value storage
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            r_key[slot_idx] <= i_key;
            r_val[slot_idx] <= i_value;
        end else if (do_write) begin
            r_val[hit_idx] <= i_value;
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import lkvc_pkg::*;

    localparam int CACHE_DEPTH    = DEF_ENTRIES;
    localparam int SET_LATENCY    = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    // expected answer of one lookup
    typedef struct {
        logic                  hit;
        logic [FIELD_BITS-1:0] value;
    } t_lookup_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_req_type;
    logic [FIELD_BITS-1:0] i_lookup_key;
    logic [FIELD_BITS-1:0] i_write_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_hit;
    logic [FIELD_BITS-1:0] o_read_value;
    logic                  i_cfg_we;
    logic [CAP_BITS-1:0]   i_cfg_wdata;

    // predicted contents of the store
    logic                  cache_valid [CACHE_DEPTH];
    logic [FIELD_BITS-1:0] cache_key   [CACHE_DEPTH];
    logic [FIELD_BITS-1:0] cache_value [CACHE_DEPTH];
    int                    cache_rank  [CACHE_DEPTH];
    int                    cache_used;
    logic [CAP_BITS-1:0]   cache_capacity;

    t_lookup_result pending_lookups[$];
    int             fail_count;
    int             send_idle_pct;
    int             recv_idle_pct;

    lru_key_value_cache_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_lookup_key (i_lookup_key),
        .i_write_value(i_write_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // store model: capacity clamped to 1..depth
    function automatic int cache_limit();
        int lim;
        lim = int'(cache_capacity);
        if (lim < 1) lim = 1;
        if (lim > CACHE_DEPTH) lim = CACHE_DEPTH;
        return lim;
    endfunction

    function automatic void cache_reset();
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_value[i] = '0;
            cache_rank[i]  = 0;
        end
        cache_used     = 0;
        cache_capacity = CAP_RESET;
    endfunction

    // move entry to the front, younger entries age by one
    function automatic void cache_touch(int e);
        int r;
        r = cache_rank[e];
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (cache_valid[i] && cache_rank[i] < r) cache_rank[i]++;
        end
        cache_rank[e] = 0;
    endfunction

    // drop the oldest entry, then place the new key at the front
    function automatic void cache_insert(logic [FIELD_BITS-1:0] k, logic [FIELD_BITS-1:0] v);
        int victim;
        int slot;
        victim = -1;
        slot   = -1;
        if (cache_used >= cache_limit()) begin
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (cache_valid[i] && (victim < 0 || cache_rank[i] > cache_rank[victim]))
                    victim = i;
            end
            if (victim >= 0) begin
                cache_valid[victim] = 1'b0;
                cache_rank[victim]  = 0;
                if (cache_used > 0) cache_used--;
            end
        end
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (!cache_valid[i] && slot < 0) slot = i;
        end
        if (slot < 0) return;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (cache_valid[i]) cache_rank[i]++;
        end
        cache_valid[slot] = 1'b1;
        cache_key[slot]   = k;
        cache_value[slot] = v;
        cache_rank[slot]  = 0;
        cache_used++;
    endfunction

    // apply one accepted request, queue the answer of a get
    function automatic void cache_apply(t_req_type op, logic [FIELD_BITS-1:0] k,
                                        logic [FIELD_BITS-1:0] v);
        int             e;
        t_lookup_result answer;
        e = -1;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (e < 0 && cache_valid[i] && cache_key[i] == k) e = i;
        end
        if (op == REQ_GET) begin
            if (e >= 0) begin
                cache_touch(e);
                answer.hit   = 1'b1;
                answer.value = cache_value[e];
            end else begin
                answer.hit   = 1'b0;
                answer.value = '1;
            end
            pending_lookups.push_back(answer);
        end else if (e >= 0) begin
            cache_value[e] = v;
            cache_touch(e);
        end else begin
            cache_insert(k, v);
        end
    endfunction

    // drive one request word and wait until it is taken
    task automatic send_request(t_req_type op, logic [FIELD_BITS-1:0] k,
                                logic [FIELD_BITS-1:0] v);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid    = 1'b0;
            i_req_type    = 1'($urandom_range(1));
            i_lookup_key  = $urandom;
            i_write_value = $urandom;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_req_type    = op;
        i_lookup_key  = k;
        i_write_value = v;
        do @(posedge i_clk); while (o_in_stall);
        cache_apply(op, k, v);
    endtask

    // stop sending until every answer is back and any set has settled
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_lookups.size() > 0) @(posedge i_clk);
        repeat (SET_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] cap);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        @(negedge i_clk);
        i_cfg_we       = 1'b0;
        cache_capacity = cap;
    endtask

    // mostly keys from a small pool so hits, updates and evictions happen
    task automatic run_random_traffic(int count, int pool_size);
        logic [FIELD_BITS-1:0] pool [32];
        logic [FIELD_BITS-1:0] k;
        t_req_type             op;
        for (int i = 0; i < 32; i++) pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            op = $urandom_range(1) ? REQ_SET : REQ_GET;
            if ($urandom_range(99) < 85) k = pool[$urandom_range(pool_size - 1)];
            else k = $urandom;
            send_request(op, k, $urandom);
        end
    endtask

    // extremes of key and value, update of a present key, misses
    task automatic test_store_and_lookup();
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_SET, 32'h7fff_ffff, 32'h8000_0000);
        send_request(REQ_SET, 32'h8000_0000, 32'h7fff_ffff);
        send_request(REQ_SET, 32'h0000_0000, 32'hffff_ffff);
        send_request(REQ_SET, 32'hffff_ffff, 32'h0000_0000);
        send_request(REQ_GET, 32'h7fff_ffff, 32'hffff_ffff);
        send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_GET, 32'hffff_ffff, 32'h0000_0000);
        send_request(REQ_SET, 32'h0000_0000, 32'h1234_5678);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
        drain();
    endtask

    // capacity of one, and zero which acts as one
    task automatic test_tiny_capacity();
        write_capacity(5'd1);
        send_request(REQ_SET, 32'h0000_00a5, 32'h0000_0011);
        send_request(REQ_SET, 32'h0000_005a, 32'h0000_0022);
        send_request(REQ_GET, 32'h0000_00a5, 32'h0000_0000);
        send_request(REQ_GET, 32'h0000_005a, 32'h0000_0000);
        write_capacity(5'd0);
        send_request(REQ_SET, 32'hdead_beef, 32'h0000_0033);
        send_request(REQ_GET, 32'h0000_005a, 32'h0000_0000);
        send_request(REQ_GET, 32'hdead_beef, 32'h0000_0000);
        drain();
    endtask

    // sender idles a little, receiver stalls most cycles
    task automatic test_busy_receiver();
        send_idle_pct = 20;
        recv_idle_pct = 79;
        write_capacity(5'd16);
        run_random_traffic(200, 24);
        drain();
        run_random_traffic(200, 24);
        write_capacity(5'd1);
        run_random_traffic(100, 4);
        drain();
    endtask

    // sender idles most cycles, receiver stalls a little
    task automatic test_busy_sender();
        send_idle_pct = 79;
        recv_idle_pct = 20;
        write_capacity(5'd31);
        run_random_traffic(300, 24);
        write_capacity(5'd0);
        run_random_traffic(100, 3);
        drain();
    endtask

    // back to back words, mid sizes and capacity lowered under a full store
    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(5'($urandom_range(4, 12)));
        run_random_traffic(330, 16);
        write_capacity(5'd16);
        run_random_traffic(150, 24);
        write_capacity(5'd3);
        run_random_traffic(150, 24);
        drain();
    endtask

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_GET;
        i_lookup_key  = '0;
        i_write_value = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        fail_count    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cache_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_store_and_lookup();
        test_tiny_capacity();
        test_busy_receiver();
        test_busy_sender();
        test_full_rate();

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[lru_key_value_cache_unit] OK");
        end else begin
            $display("[lru_key_value_cache_unit] ERROR");
        end
        $finish;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < recv_idle_pct);
    end

    // compare each result word with the oldest expected answer
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result word: hit %0d value %h", o_hit, o_read_value);
                fail_count++;
            end else begin
                want = pending_lookups.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, o_hit);
                    fail_count++;
                end
                if (o_read_value !== want.value) begin
                    $error("read_value: expected %h actual %h", want.value, o_read_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int stuck;
        stuck = 0;
        @(posedge i_rst_n);
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                stuck = 0;
            else
                stuck++;
        end
        $display("[lru_key_value_cache_unit] ERROR");
        $finish;
    end

endmodule
